@@ rtl/itb_pkg.sv @@
// ----------------------------------------------------------------------------
// itb_pkg
// Shared constants and types for the interval timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package itb_pkg;

   localparam int TIMER_COUNT = 8;
   localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int CNT_W       = $clog2(TIMER_COUNT + 1);
   localparam int TIME_W      = 63;
   localparam int EXP_W       = 64;
   localparam int DIV_CNT_W   = $clog2(TIME_W);

   typedef enum logic [1:0] {
      MODE_SET   = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CHECK = 2'd2,
      MODE_CLEAR = 2'd3
   } itb_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FINISH
   } itb_state_type;

endpackage

`default_nettype wire

@@ rtl/itb_ram.sv @@
// ----------------------------------------------------------------------------
// itb_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module itb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/interval_timer_bank.sv @@
// ----------------------------------------------------------------------------
// interval_timer_bank
// Bank of microsecond interval timers: check and fire, read, set, clear all.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  mode, timer_index, now, value, interval
//  rsp      out        rsp_valid/rsp_ready  fired, remaining, period, armed_count
//
//  A transaction is accepted in idle, where the RAM read is issued, then runs
//  lookup, update and finish: finish loads the result register and returns to
//  idle, where the next transaction can be accepted. A periodic timer that
//  fires also runs divide, between lookup and update, for the bit-serial
//  catch-up remainder (one bit a cycle).
//  One transaction is in flight at a time; the result register lets the next
//  transaction be accepted while the previous result waits.
//  Finish stalls while the result register is still full.
//  Reset is synchronous; armed and period-valid bits clear at once.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_timer_bank
   import itb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_mode,
   input  wire logic [2:0]        req_timer_index,
   input  wire logic [TIME_W-1:0] req_now_us,
   input  wire logic [TIME_W-1:0] req_value_us,
   input  wire logic [TIME_W-1:0] req_interval_us,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_fired,
   output logic [TIME_W-1:0]      rsp_remaining_us,
   output logic [TIME_W-1:0]      rsp_period_us,
   output logic [3:0]             rsp_armed_count
);

   itb_state_type         state_ff, state_in;

   itb_mode_type          mode_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic                  in_range_ff;
   logic [TIME_W-1:0]     now_ff, value_ff, interval_ff;

   logic [TIMER_COUNT-1:0] armed_ff, armed_in;
   logic [TIMER_COUNT-1:0] pvalid_ff, pvalid_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic [EXP_W-1:0]      exp_ff, exp_in;
   logic [TIME_W-1:0]     per_ff, per_in;
   logic                  fire_ff, fire_in;
   logic                  arm0_ff, arm0_in;
   logic                  chk_armed_ff, chk_armed_in;
   logic [TIME_W-1:0]     dvd_ff, dvd_in;
   logic [TIME_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_fired_ff, rsp_fired_in;
   logic [TIME_W-1:0]     rsp_rem_ff, rsp_rem_in;
   logic [TIME_W-1:0]     rsp_per_ff, rsp_per_in;
   logic [3:0]            rsp_cnt_ff, rsp_cnt_in;

   logic [EXP_W-1:0]      exp_rd;
   logic [TIME_W-1:0]     per_rd;
   logic                  exp_we, per_we;
   logic [EXP_W-1:0]      exp_wdata;

   logic                  accept, finish_go;
   logic [EXP_W:0]        lk_diff;
   logic [EXP_W:0]        div_trial;
   logic [EXP_W-1:0]      div_shift;
   logic [EXP_W:0]        fin_diff;
   logic                  fin_later;
   logic                  arm_new;
   logic                  rpt;

   assign accept    = req_valid && req_ready;
   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   itb_ram #(.WIDTH(EXP_W), .DEPTH(TIMER_COUNT)) u_exp_ram (
      .clock   (clock),
      .wr_en   (exp_we),
      .wr_addr (idx_ff),
      .wr_data (exp_wdata),
      .rd_addr (IDX_W'(req_timer_index)),
      .rd_data (exp_rd)
   );

   itb_ram #(.WIDTH(TIME_W), .DEPTH(TIMER_COUNT)) u_per_ram (
      .clock   (clock),
      .wr_en   (per_we),
      .wr_addr (idx_ff),
      .wr_data (interval_ff),
      .rd_addr (IDX_W'(req_timer_index)),
      .rd_data (per_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (fire_in && (per_in != '0)) state_in = ST_DIVIDE;
            else state_in = ST_UPDATE;
         end
         ST_DIVIDE: begin
            if (bit_cnt_ff == '0) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);

      exp_in       = exp_ff;
      per_in       = per_ff;
      fire_in      = fire_ff;
      arm0_in      = arm0_ff;
      chk_armed_in = chk_armed_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      armed_in     = armed_ff;
      pvalid_in    = pvalid_ff;
      count_in     = count_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_fired_in = rsp_fired_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_per_in   = rsp_per_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      exp_we       = 1'b0;
      per_we       = 1'b0;
      exp_wdata    = exp_ff;

      lk_diff   = {2'b00, now_ff} - {1'b0, exp_rd};
      div_shift = {rem_ff, dvd_ff[TIME_W-1]};
      div_trial = {1'b0, div_shift} - {2'b00, per_ff};
      fin_diff  = {1'b0, exp_ff} - {2'b00, now_ff};
      fin_later = !fin_diff[EXP_W] && (fin_diff[EXP_W-1:0] != '0);
      arm_new   = chk_armed_ff;
      rpt       = fire_ff && (per_ff != '0);

      unique case (state_ff)
         ST_LOOKUP: begin
            exp_in       = exp_rd;
            per_in       = pvalid_ff[idx_ff] ? per_rd : '0;
            arm0_in      = in_range_ff && armed_ff[idx_ff];
            chk_armed_in = arm0_in;
            fire_in      = arm0_in && (mode_ff != MODE_CLEAR) && !lk_diff[EXP_W];
            dvd_in       = lk_diff[TIME_W-1:0];
            rem_in       = '0;
            bit_cnt_in   = DIV_CNT_W'(TIME_W - 1);
         end
         ST_DIVIDE: begin
            dvd_in     = dvd_ff << 1;
            rem_in     = div_trial[EXP_W] ? div_shift[TIME_W-1:0] : div_trial[TIME_W-1:0];
            bit_cnt_in = bit_cnt_ff - 1'b1;
         end
         ST_UPDATE: begin
            // catch-up expiry: now - ((now - expiry) mod period) + period
            if (rpt) begin
               exp_in = {1'b0, now_ff} + {1'b0, per_ff} - {1'b0, rem_ff};
            end else if (fire_ff) begin
               chk_armed_in = 1'b0;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               rsp_valid_in = 1'b1;
               rsp_fired_in = 1'b0;
               rsp_rem_in   = '0;
               rsp_per_in   = '0;
               if (mode_ff == MODE_CLEAR) begin
                  armed_in  = '0;
                  pvalid_in = '0;
                  count_in  = '0;
               end else if (in_range_ff) begin
                  rsp_fired_in = fire_ff;
                  if ((mode_ff == MODE_SET) || (mode_ff == MODE_READ)) begin
                     rsp_rem_in = (chk_armed_ff && fin_later) ?
                                  fin_diff[TIME_W-1:0] : '0;
                     rsp_per_in = per_ff;
                  end
                  if (mode_ff == MODE_SET) begin
                     arm_new   = (value_ff != '0);
                     per_we    = 1'b1;
                     pvalid_in[idx_ff] = 1'b1;
                     exp_we    = arm_new;
                     exp_wdata = {1'b0, now_ff} + {1'b0, value_ff};
                  end else begin
                     exp_we    = rpt;
                     exp_wdata = exp_ff;
                  end
                  armed_in[idx_ff] = arm_new;
                  count_in = count_ff - CNT_W'(arm0_ff && !arm_new)
                                      + CNT_W'(!arm0_ff && arm_new);
               end
               rsp_cnt_in = (7'(count_in) > 7'd15) ? 4'd15 : 4'(count_in);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         armed_ff     <= '0;
         pvalid_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         pvalid_ff    <= pvalid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff     <= itb_mode_type'(req_mode);
         idx_ff      <= IDX_W'(req_timer_index);
         in_range_ff <= (7'(req_timer_index) < 7'(TIMER_COUNT));
         now_ff      <= req_now_us;
         value_ff    <= req_value_us;
         interval_ff <= req_interval_us;
      end
      exp_ff       <= exp_in;
      per_ff       <= per_in;
      fire_ff      <= fire_in;
      arm0_ff      <= arm0_in;
      chk_armed_ff <= chk_armed_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      bit_cnt_ff   <= bit_cnt_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_rem_ff   <= rsp_rem_in;
      rsp_per_ff   <= rsp_per_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fired        = rsp_fired_ff;
   assign rsp_remaining_us = rsp_rem_ff;
   assign rsp_period_us    = rsp_per_ff;
   assign rsp_armed_count  = rsp_cnt_ff;

endmodule

`default_nettype wire

@@ rtl/itb_checker.sv @@
// ----------------------------------------------------------------------------
// itb_checker
// Port-level assertions for the interval timer bank, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module itb_checker
   import itb_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_fired,
   input wire logic [TIME_W-1:0] rsp_remaining_us,
   input wire logic [TIME_W-1:0] rsp_period_us,
   input wire logic [3:0]        rsp_armed_count
);

   localparam int CountMax = (TIMER_COUNT > 15) ? 15 : TIMER_COUNT;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fired)
         && $stable(rsp_remaining_us) && $stable(rsp_period_us)
         && $stable(rsp_armed_count))
      else $error("result changed while stalled");

   // one transaction in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // count bounded by bank size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_armed_count <= 4'(CountMax)))
      else $error("armed count exceeds bank size");

endmodule

bind interval_timer_bank itb_checker u_itb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_fired        (rsp_fired),
   .rsp_remaining_us (rsp_remaining_us),
   .rsp_period_us    (rsp_period_us),
   .rsp_armed_count  (rsp_armed_count)
);

`default_nettype wire

@@ tb/sv/interval_timer_bank_test.sv @@
// ----------------------------------------------------------------------------
// interval_timer_bank_test
// Self-checking regression for the interval timer bank. A shadow of the eight
// timers predicts every response: firing, one-shot disarm, periodic catch-up,
// read-back, set with a 64-bit arming sum, and clear-all. A directed sequence
// covers the field extremes, then several hundred random transactions follow
// per-timer clocks so that timers really expire, mixed with random noise.
// Request bursts and response back-pressure vary throughout the run.
// ----------------------------------------------------------------------------
module interval_timer_bank_test
   import itb_pkg::*;
();

   localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 450;

   typedef struct packed {
      logic              fired;
      logic [TIME_W-1:0] remaining;
      logic [TIME_W-1:0] period;
      logic [3:0]        count;
   } timer_reply_type;

   class timer_bank_shadow;
      logic             armed [TIMER_COUNT];
      logic [EXP_W-1:0] period [TIMER_COUNT];
      logic [EXP_W-1:0] deadline [TIMER_COUNT];
      int               armed_num;
      timer_reply_type  pending_replies[$];
      int               errors;

      function new();
         for (int i = 0; i < TIMER_COUNT; i++) begin
            armed[i] = 1'b0;
            period[i] = '0;
            deadline[i] = '0;
         end
         armed_num = 0;
         errors = 0;
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      function void note_request(itb_mode_type m, logic [2:0] idx, logic [TIME_W-1:0] now,
                                 logic [TIME_W-1:0] value, logic [TIME_W-1:0] interval);
         timer_reply_type r;
         logic [EXP_W-1:0] now64;
         logic [EXP_W-1:0] steps;
         logic [EXP_W-1:0] left;
         r = '0;
         now64 = {1'b0, now};
         if (m == MODE_CLEAR) begin
            for (int i = 0; i < TIMER_COUNT; i++) begin
               armed[i] = 1'b0;
               period[i] = '0;
               deadline[i] = '0;
            end
            armed_num = 0;
         end else if (idx < TIMER_COUNT) begin
            if (armed[idx] && now64 >= deadline[idx]) begin
               r.fired = 1'b1;
               if (period[idx] == 0) begin
                  armed[idx] = 1'b0;
                  deadline[idx] = '0;
                  armed_num--;
               end else begin
                  steps = (now64 - deadline[idx]) / period[idx] + 1;
                  deadline[idx] = deadline[idx] + steps * period[idx];
               end
            end
            if (m == MODE_SET || m == MODE_READ) begin
               left = (armed[idx] && deadline[idx] > now64) ? deadline[idx] - now64 : '0;
               r.remaining = left[TIME_W-1:0];
               r.period = period[idx][TIME_W-1:0];
            end
            if (m == MODE_SET) begin
               period[idx] = {1'b0, interval};
               if (value == 0) begin
                  if (armed[idx]) armed_num--;
                  armed[idx] = 1'b0;
                  deadline[idx] = '0;
               end else begin
                  deadline[idx] = now64 + {1'b0, value};
                  if (!armed[idx]) armed_num++;
                  armed[idx] = 1'b1;
               end
            end
         end
         r.count = (armed_num > 15) ? 4'd15 : 4'(armed_num);
         pending_replies.push_back(r);
      endfunction

      function void report(string what, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
         errors++;
         if (errors <= 10)
            $display("rsp mismatch on %s: expected %0d, got %0d", what, want, got);
      endfunction

      function void check_response(timer_reply_type got);
         timer_reply_type want;
         if (pending_replies.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("rsp transaction with no request outstanding: %p", got);
            return;
         end
         want = pending_replies.pop_front();
         if (got.fired !== want.fired)         report("fired", TIME_W'(want.fired),
                                                      TIME_W'(got.fired));
         if (got.remaining !== want.remaining) report("remaining_us", want.remaining,
                                                      got.remaining);
         if (got.period !== want.period)       report("period_us", want.period, got.period);
         if (got.count !== want.count)         report("armed_count", TIME_W'(want.count),
                                                      TIME_W'(got.count));
      endfunction
   endclass

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_mode = MODE_READ;
   logic [2:0]        req_timer_index = '0;
   logic [TIME_W-1:0] req_now_us = '0;
   logic [TIME_W-1:0] req_value_us = '0;
   logic [TIME_W-1:0] req_interval_us = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_fired;
   logic [TIME_W-1:0] rsp_remaining_us;
   logic [TIME_W-1:0] rsp_period_us;
   logic [3:0]        rsp_armed_count;

   timer_bank_shadow  shadow = new();
   int                burst_left = 0;
   int                idle_cycles = 0;
   logic [11:0]       ready_cycle = '0;
   int                stall_left = 0;
   logic [TIME_W-1:0] timer_clock [TIMER_COUNT];

   interval_timer_bank dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_timer_index  (req_timer_index),
      .req_now_us       (req_now_us),
      .req_value_us     (req_value_us),
      .req_interval_us  (req_interval_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_fired        (rsp_fired),
      .rsp_remaining_us (rsp_remaining_us),
      .rsp_period_us    (rsp_period_us),
      .rsp_armed_count  (rsp_armed_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // response back-pressure: a pattern chosen by bits 9:8 of a free-running counter
   always @(posedge clock) begin
      ready_cycle <= ready_cycle + 1'b1;
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         case (ready_cycle[9:8])
            2'd1: begin
               if ($urandom_range(0, 2) == 0) stall_left <= $urandom_range(1, 3);
            end
            2'd2: begin
               if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(5, 24);
            end
            2'd3: stall_left <= 1;
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         shadow.check_response({rsp_fired, rsp_remaining_us, rsp_period_us, rsp_armed_count});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("interval_timer_bank regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(itb_mode_type m, logic [2:0] idx, logic [TIME_W-1:0] now,
                            logic [TIME_W-1:0] value, logic [TIME_W-1:0] interval);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         burst_left = $urandom_range(1, 40);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_mode <= m;
      req_timer_index <= idx;
      req_now_us <= now;
      req_value_us <= value;
      req_interval_us <= interval;
      do @(posedge clock); while (!req_ready);
      shadow.note_request(m, idx, now, value, interval);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (shadow.pending() != 0);
   endtask

   function automatic logic [TIME_W-1:0] random_bits();
      logic [TIME_W-1:0] v;
      int w;
      v = TIME_W'({$urandom, $urandom});
      w = $urandom_range(1, TIME_W);
      if (w < TIME_W) v = v & ((63'd1 << w) - 63'd1);
      return v;
   endfunction

   task automatic random_item();
      itb_mode_type m;
      logic [2:0] idx;
      logic [TIME_W-1:0] now, value, interval, step;
      int pick;
      pick = $urandom_range(0, 99);
      m = (pick < 4) ? MODE_CLEAR : (pick < 34) ? MODE_SET : (pick < 58) ? MODE_READ : MODE_CHECK;
      idx = 3'($urandom_range(0, TIMER_COUNT - 1));
      if ($urandom_range(0, 99) < 85) begin
         pick = $urandom_range(0, 99);
         step = TIME_W'((pick < 25) ? $urandom_range(0, 3) :
                        (pick < 60) ? $urandom_range(0, 200) :
                        (pick < 85) ? $urandom_range(0, 5000) : $urandom_range(0, 200000));
         timer_clock[idx] = timer_clock[idx] + step;
         now = timer_clock[idx];
         value = ($urandom_range(0, 9) == 0) ? '0 : TIME_W'($urandom_range(1, 2000));
         pick = $urandom_range(0, 9);
         interval = (pick < 3) ? '0 : (pick < 8) ? TIME_W'($urandom_range(1, 500)) :
                    TIME_W'($urandom_range(1, 50000));
      end else begin
         now = random_bits();
         value = random_bits();
         interval = random_bits();
      end
      send_item(m, idx, now, value, interval);
   endtask

   initial begin
      for (int i = 0; i < TIMER_COUNT; i++) timer_clock[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_item(MODE_READ,  3'd0, '0,        T_MAX, T_MAX);
      send_item(MODE_CHECK, 3'd0, T_MAX,     T_MAX, '0);
      send_item(MODE_SET,   3'd0, '0,        T_MAX, '0);
      send_item(MODE_READ,  3'd0, T_MAX - 1, '0,    '0);
      send_item(MODE_CHECK, 3'd0, T_MAX,     '0,    '0);
      // arming sum crosses 2^63
      send_item(MODE_SET,   3'd1, T_MAX,     T_MAX, T_MAX);
      send_item(MODE_READ,  3'd1, T_MAX,     '0,    '0);
      send_item(MODE_CHECK, 3'd1, T_MAX,     '0,    '0);
      send_item(MODE_SET,   3'd2, 63'd100,   63'd10, 63'd1);
      send_item(MODE_CHECK, 3'd2, 63'd110,   '0,    '0);
      // catch-up over nearly 2^63 periods
      send_item(MODE_CHECK, 3'd2, T_MAX,     '0,    '0);
      send_item(MODE_READ,  3'd2, T_MAX,     '0,    '0);
      send_item(MODE_SET,   3'd3, 63'd5,     63'd1, 63'd7);
      send_item(MODE_CHECK, 3'd3, 63'd1000,  '0,    '0);
      send_item(MODE_READ,  3'd3, 63'd1000,  '0,    '0);
      send_item(MODE_SET,   3'd3, 63'd1000,  '0,    '0);
      send_item(MODE_SET,   3'd7, '0,        63'd1, T_MAX);
      send_item(MODE_CHECK, 3'd7, 63'd1,     '0,    '0);
      send_item(MODE_READ,  3'd7, 63'd1,     '0,    '0);
      send_item(MODE_SET,   3'd4, 63'd50,    63'd20, 63'd3);
      send_item(MODE_SET,   3'd5, 63'd50,    63'd20, '0);
      send_item(MODE_SET,   3'd6, 63'd50,    T_MAX, 63'd9);
      send_item(MODE_SET,   3'd4, 63'd60,    63'd5, 63'd4);
      send_item(MODE_CLEAR, 3'd5, T_MAX,     T_MAX, T_MAX);
      send_item(MODE_READ,  3'd6, '0,        '0,    '0);
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain();
         random_item();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (shadow.pending() != 0);
      repeat (100) @(posedge clock);
      if (shadow.errors == 0 && shadow.pending() == 0) begin
         $display("interval_timer_bank regression: pass");
      end else begin
         $display("interval_timer_bank regression: fail");
      end
      $finish;
   end
endmodule

@@ files.f @@
rtl/itb_pkg.sv
rtl/itb_ram.sv
rtl/interval_timer_bank.sv
rtl/itb_checker.sv
tb/sv/interval_timer_bank_test.sv
